>>> design/tti_pkg.sv
// shared constants, types and helpers of the text to integer parser
package tti_pkg;

  localparam int unsigned MaxLenDefault = 4095;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned DigitW  = 7;

  localparam logic [2:0] PhWs     = 3'd0;
  localparam logic [2:0] PhSign   = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhDigits = 3'd3;
  localparam logic [2:0] PhDrain  = 3'd4;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChLoX   = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;
  localparam logic [CharW-1:0] ChLoB   = 8'h62;
  localparam logic [CharW-1:0] ChUpB   = 8'h42;

  localparam logic [BaseW-1:0] BaseBin = 6'd2;
  localparam logic [BaseW-1:0] BaseOct = 6'd8;
  localparam logic [BaseW-1:0] BaseDec = 6'd10;
  localparam logic [BaseW-1:0] BaseHex = 6'd16;

  localparam logic [DigitW-1:0] NoDigit = 7'd64;

  typedef struct packed {
    logic [2:0]        phase;
    logic [ValueW-1:0] acc;
    logic              minus;
    logic [BaseW-1:0]  base;
  } parse_state_t;

  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    d = NoDigit;
    if (c inside {[8'h30:8'h39]}) begin
      d = DigitW'(c - 8'h30);
    end else if (c inside {[8'h61:8'h7a]}) begin
      d = DigitW'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41:8'h5a]}) begin
      d = DigitW'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

>>> design/tti_if.sv
// word channels of the text to integer parser
interface tti_in_if
  import tti_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface tti_out_if
  import tti_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  value;
  logic [OffsetW-1:0] end_offset;
  logic [BaseW-1:0]   base_used;
  logic               was_negative;

  modport source (output valid, output value, output end_offset, output base_used,
                  output was_negative, input ready);
  modport sink (input valid, input value, input end_offset, input base_used,
                input was_negative, output ready);
endinterface

>>> design/tti_step.sv
// next parse state and result for one character
module tti_step
  import tti_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault,
  parameter int unsigned CntW    = $clog2(MAX_LEN + 1)
) (
  input  parse_state_t       cur_i,
  input  logic [CntW-1:0]    cnt_i,
  input  logic [CharW-1:0]   char_i,
  input  logic [BaseW-1:0]   radix_i,
  output parse_state_t       nxt_o,
  output logic [CntW-1:0]    cnt_o,
  output logic               emit_o,
  output logic [ValueW-1:0]  value_o,
  output logic [OffsetW-1:0] end_offset_o,
  output logic [BaseW-1:0]   base_used_o,
  output logic               was_negative_o
);

  logic [CntW-1:0]          cnt_inc;
  logic [DigitW-1:0]        digit;
  logic                     do_start;
  logic                     do_take;
  logic [BaseW-1:0]         take_base;
  logic [CntW+OffsetW-1:0]  cnt_wide;

  assign cnt_inc  = (cnt_i < CntW'(MAX_LEN)) ? cnt_i + CntW'(1) : cnt_i;
  assign digit    = digit_of(char_i);
  assign cnt_wide = {{OffsetW{1'b0}}, cnt_i};

  always_comb begin
    nxt_o          = cur_i;
    cnt_o          = cnt_i;
    emit_o         = 1'b0;
    do_start       = 1'b0;
    do_take        = 1'b0;
    take_base      = cur_i.base;
    value_o        = cur_i.minus ? ValueW'(0) - cur_i.acc : cur_i.acc;
    end_offset_o   = cnt_wide[OffsetW-1:0];
    base_used_o    = cur_i.base;
    was_negative_o = cur_i.minus;

    case (cur_i.phase)
      PhWs: begin
        if (char_i == ChSpace || char_i inside {[8'd9:8'd13]}) begin
          cnt_o = cnt_inc;
        end else if (char_i == ChPlus || char_i == ChMinus) begin
          nxt_o.minus = (char_i == ChMinus);
          nxt_o.phase = PhSign;
          cnt_o       = cnt_inc;
        end else begin
          do_start = 1'b1;
        end
      end
      PhSign: begin
        do_start = 1'b1;
      end
      PhZero: begin
        if (char_i == ChLoX || char_i == ChUpX) begin
          nxt_o.base  = BaseHex;
          nxt_o.phase = PhDigits;
          cnt_o       = cnt_inc;
        end else if (char_i == ChLoB || char_i == ChUpB) begin
          nxt_o.base  = BaseBin;
          nxt_o.phase = PhDigits;
          cnt_o       = cnt_inc;
        end else begin
          take_base = BaseOct;
          do_take   = 1'b1;
        end
      end
      PhDigits: begin
        do_take = 1'b1;
      end
      default: begin
        if (char_i == ChNul) begin
          nxt_o = '{phase: PhWs, acc: '0, minus: 1'b0, base: '0};
          cnt_o = '0;
        end
      end
    endcase

    if (do_start) begin
      if (radix_i == '0 && char_i == ChZero) begin
        nxt_o.phase = PhZero;
        cnt_o       = cnt_inc;
      end else begin
        take_base = (radix_i == '0) ? BaseDec : radix_i;
        do_take   = 1'b1;
      end
    end

    if (do_take) begin
      nxt_o.base = take_base;
      if (digit < {1'b0, take_base}) begin
        nxt_o.acc   = cur_i.acc * {{(ValueW-BaseW){1'b0}}, take_base}
                      + {{(ValueW-DigitW){1'b0}}, digit};
        nxt_o.phase = PhDigits;
        cnt_o       = cnt_inc;
      end else begin
        emit_o      = 1'b1;
        base_used_o = take_base;
        if (char_i == ChNul) begin
          nxt_o = '{phase: PhWs, acc: '0, minus: 1'b0, base: '0};
          cnt_o = '0;
        end else begin
          nxt_o.phase = PhDrain;
        end
      end
    end
  end

endmodule

>>> design/text_to_integer_parser_core.sv
// top level of the streaming text to integer parser
//
// in_i carries one string character per word, NUL (zero) ending the string.
// Leading white space and one sign are skipped; with radix 0 a 0x, 0b or
// leading 0 prefix picks the base, otherwise radix is the base. Digits are
// accumulated into 64 bits; the first non-digit or the NUL yields one word
// on out_o with the value, the characters consumed, the base and the sign.
// Characters up to the NUL after that are dropped without output.
// cfg_we_i/cfg_wdata_i write the radix register; write it only while idle.
// One character is taken per cycle while out_o is not stalled. A character is
// held in the input register until it is folded into the parse state, and a
// result it causes is on out_o from the edge that folds it in.
// A waiting result holds out_o and the next character in the input register;
// in_i.ready drops only while both are full and out_o is not being taken.
// Reset clears the parse state, the radix (automatic detection) and the valid
// flags of both word registers; in_i.ready is high once reset is released.
module text_to_integer_parser_core
  import tti_pkg::*;
#(
  parameter int unsigned MAX_LEN = MaxLenDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BaseW-1:0] cfg_wdata_i,
  tti_in_if.sink           in_i,
  tti_out_if.source        out_o
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);

  logic               in_vld_q;
  logic [CharW-1:0]   char_q;
  logic [BaseW-1:0]   radix_q;
  parse_state_t       state_q;
  parse_state_t       state_d;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    cnt_d;
  logic               emit;
  logic               go;
  logic               out_vld_q;
  logic [ValueW-1:0]  value_d;
  logic [ValueW-1:0]  value_q;
  logic [OffsetW-1:0] end_offset_d;
  logic [OffsetW-1:0] end_offset_q;
  logic [BaseW-1:0]   base_used_d;
  logic [BaseW-1:0]   base_used_q;
  logic               was_negative_d;
  logic               was_negative_q;

  tti_step #(
    .MAX_LEN (MAX_LEN),
    .CntW    (CntW)
  ) u_step (
    .cur_i          (state_q),
    .cnt_i          (cnt_q),
    .char_i         (char_q),
    .radix_i        (radix_q),
    .nxt_o          (state_d),
    .cnt_o          (cnt_d),
    .emit_o         (emit),
    .value_o        (value_d),
    .end_offset_o   (end_offset_d),
    .base_used_o    (base_used_d),
    .was_negative_o (was_negative_d)
  );

  assign go         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      radix_q   <= '0;
      state_q   <= '{phase: PhWs, acc: '0, minus: 1'b0, base: '0};
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (go) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
      end
      if (go && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // word payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q <= in_i.char_in;
    end
    if (go && emit) begin
      value_q        <= value_d;
      end_offset_q   <= end_offset_d;
      base_used_q    <= base_used_d;
      was_negative_q <= was_negative_d;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.value        = value_q;
  assign out_o.end_offset   = end_offset_q;
  assign out_o.base_used    = base_used_q;
  assign out_o.was_negative = was_negative_q;

endmodule
